@@ design/i2cebm_pkg.sv @@
package i2cebm_pkg;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_LOCKED    = 3'd1;
   localparam logic [2:0] STATUS_ADDR_NACK = 3'd2;
   localparam logic [2:0] STATUS_REG_NACK  = 3'd3;
   localparam logic [2:0] STATUS_DATA_NACK = 3'd4;
   localparam logic [2:0] STATUS_RADR_NACK = 3'd5;

   localparam logic [7:0] CHECK_LIMIT_RESET = 8'd17;

   localparam logic LINE_SCL = 1'b0;
   localparam logic LINE_SDA = 1'b1;

   localparam logic RW_WRITE = 1'b0;
   localparam logic RW_READ  = 1'b1;

   typedef struct packed {
      logic [1:0] kind;
      logic       port;
      logic [6:0] device_address;
      logic [7:0] register_address;
      logic [7:0] write_byte;
      logic       sda_sample;
   } req_type;

   typedef struct packed {
      logic       scl_port_a;
      logic       sda_port_a;
      logic       scl_port_b;
      logic       sda_port_b;
      logic       busy_res;
      logic       done_res;
      logic [2:0] status;
      logic [7:0] read_byte;
   } rsp_type;

endpackage

@@ design/i2cebm_engine.sv @@
module i2cebm_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  i2cebm_pkg::req_type item,
   input  logic [7:0]          limit,
   output i2cebm_pkg::rsp_type result
);
   import i2cebm_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_CHECK, PH_START, PH_DEVW, PH_DEVW_ACK, PH_REG, PH_REG_ACK,
      PH_DATA, PH_DATA_ACK, PH_RSTART, PH_DEVR, PH_DEVR_ACK, PH_READ, PH_NACK,
      PH_STOP
   } phase_type;

   // A tick runs at most two actions: a sample that yields no pin update,
   // then the pin update that follows it.
   localparam int ACT_PASSES = 2;

   phase_type  phase_ff, phase_in;
   logic [1:0] half_ff, half_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] pulse_ff, pulse_in;
   logic [3:0] pins_ff, pins_in;
   logic       lat_write_ff, lat_write_in;
   logic       lat_port_ff, lat_port_in;
   logic [6:0] lat_dev_ff, lat_dev_in;
   logic [7:0] lat_reg_ff, lat_reg_in;
   logic [7:0] lat_data_ff, lat_data_in;
   rsp_type    result_ff, result_in;
   logic       again;
   logic       done;
   logic [2:0] status;

   function automatic logic [3:0] drive_pin(input logic [3:0] pins, input logic port,
                                            input logic line, input logic level);
      logic [3:0] next;
      next = pins;
      next[{port, line}] = level;
      return next;
   endfunction

   always_comb begin
      phase_in     = phase_ff;
      half_in      = half_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      pulse_in     = pulse_ff;
      pins_in      = pins_ff;
      lat_write_in = lat_write_ff;
      lat_port_in  = lat_port_ff;
      lat_dev_in   = lat_dev_ff;
      lat_reg_in   = lat_reg_ff;
      lat_data_in  = lat_data_ff;
      done         = 1'b0;
      status       = STATUS_OK;
      again        = 1'b1;

      if (phase_ff == PH_IDLE && (item.kind == KIND_READ || item.kind == KIND_WRITE)) begin
         lat_write_in = (item.kind == KIND_WRITE);
         lat_port_in  = item.port;
         lat_dev_in   = item.device_address;
         lat_reg_in   = item.register_address;
         lat_data_in  = item.write_byte;
         phase_in     = PH_CHECK;
         half_in      = 2'd0;
         bit_in       = 3'd0;
         shift_in     = 8'd0;
         pulse_in     = 8'd0;
      end

      for (int p = 0; p < ACT_PASSES; p++) begin
         if (again && phase_in != PH_IDLE) begin
            again = 1'b0;
            unique case (phase_in) inside
               PH_CHECK, PH_DEVW_ACK, PH_REG_ACK, PH_DATA_ACK, PH_DEVR_ACK, PH_READ: begin
                  if (half_in != 2'd3) begin
                     case (half_in)
                        2'd0:    pins_in = drive_pin(pins_in, lat_port_in, LINE_SCL, 1'b0);
                        2'd1:    pins_in = drive_pin(pins_in, lat_port_in, LINE_SDA, 1'b1);
                        default: pins_in = drive_pin(pins_in, lat_port_in, LINE_SCL, 1'b1);
                     endcase
                     half_in = half_in + 2'd1;
                  end else begin
                     // sample taken: either end here or go on to the next update
                     again   = 1'b1;
                     half_in = 2'd0;
                     bit_in  = 3'd0;
                     unique case (phase_in)
                        PH_CHECK: begin
                           if (item.sda_sample) begin
                              pulse_in = 8'd0;
                              phase_in = PH_START;
                              shift_in = 8'd0;
                           end else begin
                              pulse_in = pulse_ff + 8'd1;
                              if (pulse_in >= limit) begin
                                 done   = 1'b1;
                                 status = STATUS_LOCKED;
                              end else begin
                                 bit_in = bit_ff;
                              end
                           end
                        end
                        PH_DEVW_ACK: begin
                           if (item.sda_sample) begin
                              done   = 1'b1;
                              status = STATUS_ADDR_NACK;
                           end else begin
                              phase_in = PH_REG;
                              shift_in = lat_reg_in;
                           end
                        end
                        PH_REG_ACK: begin
                           if (item.sda_sample) begin
                              done   = 1'b1;
                              status = STATUS_REG_NACK;
                           end else if (lat_write_in) begin
                              phase_in = PH_DATA;
                              shift_in = lat_data_in;
                           end else begin
                              phase_in = PH_RSTART;
                              shift_in = 8'd0;
                           end
                        end
                        PH_DATA_ACK: begin
                           if (item.sda_sample) begin
                              done   = 1'b1;
                              status = STATUS_DATA_NACK;
                           end else begin
                              phase_in = PH_STOP;
                              shift_in = 8'd0;
                           end
                        end
                        PH_DEVR_ACK: begin
                           if (item.sda_sample) begin
                              done   = 1'b1;
                              status = STATUS_RADR_NACK;
                           end else begin
                              phase_in = PH_READ;
                              shift_in = 8'd0;
                           end
                        end
                        default: begin
                           // read: shift in one bit
                           shift_in = {shift_in[6:0], item.sda_sample};
                           if (bit_ff == 3'd7) begin
                              phase_in = PH_NACK;
                           end else begin
                              bit_in = bit_ff + 3'd1;
                           end
                        end
                     endcase
                     if (done) begin
                        again    = 1'b0;
                        phase_in = PH_IDLE;
                        bit_in   = 3'd0;
                     end
                  end
               end
               PH_START, PH_RSTART: begin
                  if (half_in == 2'd0) begin
                     pins_in = drive_pin(pins_in, lat_port_in, LINE_SCL, 1'b1);
                     pins_in = drive_pin(pins_in, lat_port_in, LINE_SDA, 1'b1);
                     half_in = 2'd1;
                  end else begin
                     pins_in = drive_pin(pins_in, lat_port_in, LINE_SDA, 1'b0);
                     half_in = 2'd0;
                     bit_in  = 3'd0;
                     if (phase_in == PH_START) begin
                        phase_in = PH_DEVW;
                        shift_in = {lat_dev_in, RW_WRITE};
                     end else begin
                        phase_in = PH_DEVR;
                        shift_in = {lat_dev_in, RW_READ};
                     end
                  end
               end
               PH_DEVW, PH_REG, PH_DATA, PH_DEVR: begin
                  if (half_in == 2'd0) begin
                     pins_in = drive_pin(pins_in, lat_port_in, LINE_SCL, 1'b0);
                     half_in = 2'd1;
                  end else if (half_in == 2'd1) begin
                     pins_in = drive_pin(pins_in, lat_port_in, LINE_SDA, shift_in[7]);
                     half_in = 2'd2;
                  end else begin
                     pins_in  = drive_pin(pins_in, lat_port_in, LINE_SCL, 1'b1);
                     shift_in = {shift_in[6:0], 1'b0};
                     half_in  = 2'd0;
                     if (bit_in == 3'd7) begin
                        bit_in = 3'd0;
                        case (phase_in)
                           PH_DEVW: phase_in = PH_DEVW_ACK;
                           PH_REG:  phase_in = PH_REG_ACK;
                           PH_DATA: phase_in = PH_DATA_ACK;
                           default: phase_in = PH_DEVR_ACK;
                        endcase
                     end else begin
                        bit_in = bit_in + 3'd1;
                     end
                  end
               end
               PH_NACK: begin
                  if (half_in == 2'd0) begin
                     pins_in = drive_pin(pins_in, lat_port_in, LINE_SCL, 1'b0);
                     half_in = 2'd1;
                  end else if (half_in == 2'd1) begin
                     pins_in = drive_pin(pins_in, lat_port_in, LINE_SDA, 1'b1);
                     half_in = 2'd2;
                  end else begin
                     pins_in  = drive_pin(pins_in, lat_port_in, LINE_SCL, 1'b1);
                     phase_in = PH_STOP;
                     half_in  = 2'd0;
                  end
               end
               PH_STOP: begin
                  case (half_in)
                     2'd0: pins_in = drive_pin(pins_in, lat_port_in, LINE_SCL, 1'b0);
                     2'd1: pins_in = drive_pin(pins_in, lat_port_in, LINE_SDA, 1'b0);
                     2'd2: pins_in = drive_pin(pins_in, lat_port_in, LINE_SCL, 1'b1);
                     default: begin
                        pins_in = drive_pin(pins_in, lat_port_in, LINE_SDA, 1'b1);
                        done    = 1'b1;
                        status  = STATUS_OK;
                     end
                  endcase
                  if (done) begin
                     phase_in = PH_IDLE;
                     half_in  = 2'd0;
                     bit_in   = 3'd0;
                  end else begin
                     half_in = half_in + 2'd1;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
                  half_in  = 2'd0;
               end
            endcase
         end
      end

      result_in.scl_port_a = pins_in[0];
      result_in.sda_port_a = pins_in[1];
      result_in.scl_port_b = pins_in[2];
      result_in.sda_port_b = pins_in[3];
      result_in.busy_res   = (phase_in != PH_IDLE);
      result_in.done_res   = done;
      result_in.status     = status;
      result_in.read_byte  = (done && status == STATUS_OK && !lat_write_in) ? shift_in : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         half_ff  <= 2'd0;
         bit_ff   <= 3'd0;
         shift_ff <= 8'd0;
         pulse_ff <= 8'd0;
         pins_ff  <= 4'hF;
      end else if (step) begin
         phase_ff <= phase_in;
         half_ff  <= half_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         pulse_ff <= pulse_in;
         pins_ff  <= pins_in;
      end
      if (step) begin
         lat_write_ff <= lat_write_in;
         lat_port_ff  <= lat_port_in;
         lat_dev_ff   <= lat_dev_in;
         lat_reg_ff   <= lat_reg_in;
         lat_data_ff  <= lat_data_in;
         result_ff    <= result_in;
      end
   end

   assign result = result_ff;

endmodule

@@ design/i2c_eeprom_byte_master.sv @@
// Two-port I2C master for single-byte random reads and writes. Each word on
// the req channel is one half-bit tick of the bus and may carry a read or
// write request (ignored while busy); each tick yields exactly one rsp word
// with the pin levels of both ports, busy, done, status and the read byte.
// A request first pulses SCL with SDA released until SDA reads high, up to
// the csr limit. A word is taken every cycle while req_stall is low; its
// response passes the input register and then the result register around
// the tick logic. csr_ready is always high.
module i2c_eeprom_byte_master (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic       req_port,
   input  logic [6:0] req_device_address,
   input  logic [7:0] req_register_address,
   input  logic [7:0] req_write_byte,
   input  logic       req_sda_sample,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl_port_a,
   output logic       rsp_sda_port_a,
   output logic       rsp_scl_port_b,
   output logic       rsp_sda_port_b,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_read_byte,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);
   import i2cebm_pkg::*;

   req_type    req_ff, req_in;
   logic       req_valid_ff, req_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] limit_ff, limit_in;
   logic       out_free;
   logic       in_free;
   logic       step;
   rsp_type    result;

   // advance when the result slot is empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign in_free   = !req_valid_ff || out_free;
   assign step      = req_valid_ff && out_free;
   assign req_stall = !in_free;
   assign csr_ready = 1'b1;

   always_comb begin
      req_in.kind             = req_kind;
      req_in.port             = req_port;
      req_in.device_address   = req_device_address;
      req_in.register_address = req_register_address;
      req_in.write_byte       = req_write_byte;
      req_in.sda_sample       = req_sda_sample;
      req_valid_in = in_free ? req_valid : req_valid_ff;
      rsp_valid_in = out_free ? req_valid_ff : rsp_valid_ff;
      limit_in     = (csr_valid && csr_ready) ? csr_data : limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= CHECK_LIMIT_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
      end
      if (in_free && req_valid) begin
         req_ff <= req_in;
      end
   end

   i2cebm_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (req_ff),
      .limit  (limit_ff),
      .result (result)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl_port_a = result.scl_port_a;
   assign rsp_sda_port_a = result.sda_port_a;
   assign rsp_scl_port_b = result.scl_port_b;
   assign rsp_sda_port_b = result.sda_port_b;
   assign rsp_busy_res   = result.busy_res;
   assign rsp_done_res   = result.done_res;
   assign rsp_status     = result.status;
   assign rsp_read_byte  = result.read_byte;

endmodule

@@ sim/i2c_eeprom_byte_master_tb.sv @@
module i2c_eeprom_byte_master_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cebm_pkg::*;

   localparam logic [1:0] KIND_SPARE = 2'd3;

   typedef enum logic [4:0] {
      PH_IDLE, PH_CHECK, PH_START, PH_DEVW, PH_DEVW_ACK, PH_REG, PH_REG_ACK,
      PH_DATA, PH_DATA_ACK, PH_RSTART, PH_DEVR, PH_DEVR_ACK, PH_READ, PH_NACK, PH_STOP
   } bus_phase_type;

   typedef struct packed {
      logic [1:0]    kind;
      logic          port;
      logic [6:0]    dev_addr;
      logic [7:0]    reg_offset;
      logic [7:0]    wr_byte;
      logic [7:0]    low_pulses;
      bus_phase_type nack_at;
      logic [7:0]    rd_byte;
      logic [2:0]    want_status;
      logic [7:0]    want_rbyte;
   } xfer_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_kind = KIND_TICK;
   logic       req_port = 1'b0;
   logic [6:0] req_device_address = '0;
   logic [7:0] req_register_address = '0;
   logic [7:0] req_write_byte = '0;
   logic       req_sda_sample = 1'b1;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_scl_port_a;
   logic       rsp_sda_port_a;
   logic       rsp_scl_port_b;
   logic       rsp_sda_port_b;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic [2:0] rsp_status;
   logic [7:0] rsp_read_byte;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = '0;

   // bus model state
   bus_phase_type bus_ph = PH_IDLE;
   logic [1:0] half = '0;
   logic [2:0] bitn = '0;
   logic [7:0] shifter = '0;
   logic [7:0] pulses = '0;
   req_type    held = '0;
   logic [3:0] lines = 4'hF;
   logic [7:0] pulse_limit = CHECK_LIMIT_RESET;
   logic       xfer_done;
   logic [2:0] xfer_status;
   logic [7:0] xfer_rbyte;

   // slave behavior for the running transfer
   logic [7:0]    plan_lows;
   bus_phase_type plan_nack;
   logic [7:0]    plan_rdata;
   logic          plan_noise;

   rsp_type    line_state_q[$];
   rsp_type    last_word;
   int         errors = 0;
   int         work_items = 0;
   int         tx_idle_pct = 0;
   int         rx_stall_pct = 0;
   bit         hold_request = 1'b0;
   int         hold_left = 0;

   xfer_row_type dir_rows [14] = '{
      '{KIND_WRITE, 1'b0, 7'h00, 8'h00, 8'h00, 8'd0, PH_IDLE, 8'h00, STATUS_OK, 8'h00},
      '{KIND_WRITE, 1'b1, 7'h7F, 8'hFF, 8'hFF, 8'd0, PH_IDLE, 8'h00, STATUS_OK, 8'h00},
      '{KIND_READ, 1'b0, 7'h7F, 8'h00, 8'h5A, 8'd0, PH_IDLE, 8'hFF, STATUS_OK, 8'hFF},
      '{KIND_READ, 1'b1, 7'h00, 8'hFF, 8'hFF, 8'd0, PH_IDLE, 8'h00, STATUS_OK, 8'h00},
      '{KIND_READ, 1'b0, 7'h55, 8'hAA, 8'h00, 8'd2, PH_IDLE, 8'hA5, STATUS_OK, 8'hA5},
      '{KIND_WRITE, 1'b1, 7'h2A, 8'h55, 8'hA5, 8'd3, PH_IDLE, 8'h00, STATUS_OK, 8'h00},
      '{KIND_WRITE, 1'b0, 7'h11, 8'h22, 8'h33, 8'd255, PH_IDLE, 8'h00, STATUS_LOCKED, 8'h00},
      '{KIND_READ, 1'b1, 7'h12, 8'h34, 8'h00, 8'd255, PH_IDLE, 8'hFF, STATUS_LOCKED, 8'h00},
      '{KIND_WRITE, 1'b1, 7'h50, 8'h01, 8'h02, 8'd0, PH_DEVW_ACK, 8'h00,
        STATUS_ADDR_NACK, 8'h00},
      '{KIND_READ, 1'b0, 7'h50, 8'h80, 8'h00, 8'd0, PH_REG_ACK, 8'hFF,
        STATUS_REG_NACK, 8'h00},
      '{KIND_WRITE, 1'b0, 7'h01, 8'h7F, 8'hC3, 8'd0, PH_REG_ACK, 8'h00,
        STATUS_REG_NACK, 8'h00},
      '{KIND_WRITE, 1'b1, 7'h3C, 8'hFE, 8'h81, 8'd0, PH_DATA_ACK, 8'h00,
        STATUS_DATA_NACK, 8'h00},
      '{KIND_READ, 1'b1, 7'h40, 8'h0F, 8'h00, 8'd0, PH_DEVR_ACK, 8'hFF,
        STATUS_RADR_NACK, 8'h00},
      '{KIND_READ, 1'b0, 7'h03, 8'hF0, 8'h00, 8'd0, PH_DEVW_ACK, 8'hFF,
        STATUS_ADDR_NACK, 8'h00}
   };

   i2c_eeprom_byte_master u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_kind             (req_kind),
      .req_port             (req_port),
      .req_device_address   (req_device_address),
      .req_register_address (req_register_address),
      .req_write_byte       (req_write_byte),
      .req_sda_sample       (req_sda_sample),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_scl_port_a       (rsp_scl_port_a),
      .rsp_sda_port_a       (rsp_sda_port_a),
      .rsp_scl_port_b       (rsp_scl_port_b),
      .rsp_sda_port_b       (rsp_sda_port_b),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_done_res         (rsp_done_res),
      .rsp_status           (rsp_status),
      .rsp_read_byte        (rsp_read_byte),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void drive_line(logic line, logic level);
      lines[{held.port, line}] = level;
   endfunction

   function automatic void enter_phase(bus_phase_type p, logic [7:0] b);
      bus_ph = p;
      half = '0;
      bitn = '0;
      shifter = b;
   endfunction

   function automatic void end_xfer(logic [2:0] st);
      xfer_done = 1'b1;
      xfer_status = st;
      xfer_rbyte = (st == STATUS_OK && held.kind == KIND_READ) ? shifter : 8'h00;
      bus_ph = PH_IDLE;
      half = '0;
      bitn = '0;
   endfunction

   // one bus action; returns 1 when the tick is used up
   function automatic logic bus_act(logic sda);
      if (bus_ph inside {PH_CHECK, PH_DEVW_ACK, PH_REG_ACK, PH_DATA_ACK, PH_DEVR_ACK,
                         PH_READ}) begin
         if (half != 2'd3) begin
            case (half)
               2'd0: drive_line(LINE_SCL, 1'b0);
               2'd1: drive_line(LINE_SDA, 1'b1);
               default: drive_line(LINE_SCL, 1'b1);
            endcase
            half = half + 2'd1;
            return 1'b1;
         end
         // sample tick: abort, or fall through to the next update
         case (bus_ph)
            PH_CHECK: begin
               if (sda) begin
                  pulses = '0;
                  enter_phase(PH_START, 8'h00);
               end else begin
                  pulses = pulses + 8'd1;
                  if (pulses >= pulse_limit) begin
                     end_xfer(STATUS_LOCKED);
                     return 1'b1;
                  end
                  half = '0;
               end
            end
            PH_DEVW_ACK: begin
               if (sda) begin
                  end_xfer(STATUS_ADDR_NACK);
                  return 1'b1;
               end
               enter_phase(PH_REG, held.register_address);
            end
            PH_REG_ACK: begin
               if (sda) begin
                  end_xfer(STATUS_REG_NACK);
                  return 1'b1;
               end
               if (held.kind == KIND_WRITE) enter_phase(PH_DATA, held.write_byte);
               else enter_phase(PH_RSTART, 8'h00);
            end
            PH_DATA_ACK: begin
               if (sda) begin
                  end_xfer(STATUS_DATA_NACK);
                  return 1'b1;
               end
               enter_phase(PH_STOP, 8'h00);
            end
            PH_DEVR_ACK: begin
               if (sda) begin
                  end_xfer(STATUS_RADR_NACK);
                  return 1'b1;
               end
               enter_phase(PH_READ, 8'h00);
            end
            default: begin
               shifter = {shifter[6:0], sda};
               half = '0;
               if (bitn == 3'd7) begin
                  bitn = '0;
                  bus_ph = PH_NACK;
               end else begin
                  bitn = bitn + 3'd1;
               end
            end
         endcase
         return 1'b0;
      end
      case (bus_ph)
         PH_START, PH_RSTART: begin
            if (half == 2'd0) begin
               drive_line(LINE_SCL, 1'b1);
               drive_line(LINE_SDA, 1'b1);
               half = 2'd1;
            end else begin
               drive_line(LINE_SDA, 1'b0);
               if (bus_ph == PH_START) enter_phase(PH_DEVW, {held.device_address, RW_WRITE});
               else enter_phase(PH_DEVR, {held.device_address, RW_READ});
            end
         end
         PH_DEVW, PH_REG, PH_DATA, PH_DEVR: begin
            if (half == 2'd0) begin
               drive_line(LINE_SCL, 1'b0);
               half = 2'd1;
            end else if (half == 2'd1) begin
               drive_line(LINE_SDA, shifter[7]);
               half = 2'd2;
            end else begin
               drive_line(LINE_SCL, 1'b1);
               shifter = {shifter[6:0], 1'b0};
               half = '0;
               if (bitn == 3'd7) begin
                  bitn = '0;
                  bus_ph = bus_phase_type'(bus_ph + 1);
               end else begin
                  bitn = bitn + 3'd1;
               end
            end
         end
         PH_NACK: begin
            if (half == 2'd0) begin
               drive_line(LINE_SCL, 1'b0);
               half = 2'd1;
            end else if (half == 2'd1) begin
               drive_line(LINE_SDA, 1'b1);
               half = 2'd2;
            end else begin
               drive_line(LINE_SCL, 1'b1);
               bus_ph = PH_STOP;
               half = '0;
            end
         end
         PH_STOP: begin
            if (half == 2'd3) begin
               drive_line(LINE_SDA, 1'b1);
               end_xfer(STATUS_OK);
            end else begin
               case (half)
                  2'd0: drive_line(LINE_SCL, 1'b0);
                  2'd1: drive_line(LINE_SDA, 1'b0);
                  default: drive_line(LINE_SCL, 1'b1);
               endcase
               half = half + 2'd1;
            end
         end
         default: begin
            bus_ph = PH_IDLE;
            half = '0;
         end
      endcase
      return 1'b1;
   endfunction

   function automatic rsp_type advance_bus(req_type w);
      rsp_type r;
      xfer_done = 1'b0;
      xfer_status = STATUS_OK;
      xfer_rbyte = 8'h00;
      if (bus_ph == PH_IDLE && (w.kind == KIND_READ || w.kind == KIND_WRITE)) begin
         held = w;
         enter_phase(PH_CHECK, 8'h00);
         pulses = '0;
      end
      for (int g = 0; g < 4; g++) begin
         if (bus_ph == PH_IDLE) break;
         if (bus_act(w.sda_sample)) break;
      end
      r.scl_port_a = lines[0];
      r.sda_port_a = lines[1];
      r.scl_port_b = lines[2];
      r.sda_port_b = lines[3];
      r.busy_res = (bus_ph != PH_IDLE);
      r.done_res = xfer_done;
      r.status = xfer_status;
      r.read_byte = xfer_rbyte;
      return r;
   endfunction

   // what the slave puts on SDA for the next tick
   function automatic logic pick_sda();
      if (plan_noise || half != 2'd3) return 1'($urandom_range(1));
      case (bus_ph)
         PH_CHECK: return (pulses < plan_lows) ? 1'b0 : 1'b1;
         PH_READ: return plan_rdata[3'd7 - bitn];
         PH_DEVW_ACK, PH_REG_ACK, PH_DATA_ACK, PH_DEVR_ACK: return bus_ph == plan_nack;
         default: return 1'($urandom_range(1));
      endcase
   endfunction

   function automatic req_type noise_word();
      req_type w;
      w.kind = 2'($urandom_range(3));
      w.port = 1'($urandom_range(1));
      w.device_address = 7'($urandom_range(127));
      w.register_address = 8'($urandom_range(255));
      w.write_byte = 8'($urandom_range(255));
      w.sda_sample = 1'($urandom_range(1));
      return w;
   endfunction

   function automatic void check_field(string name, logic [7:0] e, logic [7:0] a);
      if (a !== e) begin
         $display("%0t: %s expected %h got %h", $time, name, e, a);
         errors++;
      end
   endfunction

   task automatic send_tick(req_type w);
      rsp_type exp;
      logic    counts;
      req_valid <= 1'b1;
      req_kind <= w.kind;
      req_port <= w.port;
      req_device_address <= w.device_address;
      req_register_address <= w.register_address;
      req_write_byte <= w.write_byte;
      req_sda_sample <= w.sda_sample;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      counts = (bus_ph != PH_IDLE) || w.kind == KIND_READ || w.kind == KIND_WRITE;
      if (counts) work_items++;
      exp = advance_bus(w);
      line_state_q.push_back(exp);
      last_word = exp;
      @(posedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic run_ticks(int max_n);
      req_type w;
      int      n;
      n = 0;
      while (bus_ph != PH_IDLE && (max_n == 0 || n < max_n)) begin
         w = noise_word();
         if ($urandom_range(99) >= 15) w.kind = KIND_TICK;
         w.sda_sample = pick_sda();
         send_tick(w);
         n++;
      end
   endtask

   task automatic start_xfer(req_type w, logic [7:0] lows, bus_phase_type nack,
                             logic [7:0] rdata, logic noisy, int max_n);
      plan_lows = lows;
      plan_nack = nack;
      plan_rdata = rdata;
      plan_noise = noisy;
      w.sda_sample = 1'($urandom_range(1));
      send_tick(w);
      run_ticks(max_n);
   endtask

   task automatic random_xfer();
      req_type       w;
      logic [7:0]    lows;
      bus_phase_type nack;
      int            r;
      w = noise_word();
      w.kind = $urandom_range(1) ? KIND_READ : KIND_WRITE;
      r = $urandom_range(99);
      lows = (r < 70) ? 8'd0 : (r < 95) ? 8'($urandom_range(1, 3)) : 8'd255;
      case ($urandom_range(7))
         4: nack = PH_DEVW_ACK;
         5: nack = PH_REG_ACK;
         6: nack = PH_DATA_ACK;
         7: nack = PH_DEVR_ACK;
         default: nack = PH_IDLE;
      endcase
      start_xfer(w, lows, nack, 8'($urandom_range(255)), $urandom_range(99) < 10, 0);
      repeat ($urandom_range(2)) begin
         w = noise_word();
         w.kind = $urandom_range(1) ? KIND_SPARE : KIND_TICK;
         send_tick(w);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (line_state_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_limit(logic [7:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data <= v;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      pulse_limit = v;
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic check_done(logic [2:0] st, logic [7:0] rb);
      if (last_word.status !== st || last_word.read_byte !== rb) begin
         $display("%0t: transfer end expected status %0d byte %h got status %0d byte %h",
                  $time, st, rb, last_word.status, last_word.read_byte);
         errors++;
      end
   endtask

   // receiver: random stall, or a long hold when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left = 400;
            hold_request = 1'b0;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_stall_pct);
         end
      end
   end

   initial begin
      rsp_type got;
      rsp_type exp;
      while (reset) @(posedge clock);
      forever begin
         @(negedge clock);
         if (rsp_valid && !rsp_stall) begin
            got.scl_port_a = rsp_scl_port_a;
            got.sda_port_a = rsp_sda_port_a;
            got.scl_port_b = rsp_scl_port_b;
            got.sda_port_b = rsp_sda_port_b;
            got.busy_res = rsp_busy_res;
            got.done_res = rsp_done_res;
            got.status = rsp_status;
            got.read_byte = rsp_read_byte;
            @(posedge clock);
            if (line_state_q.size() == 0) begin
               $display("%0t: unexpected word, expected none got %h", $time, got);
               errors++;
            end else begin
               exp = line_state_q.pop_front();
               check_field("scl_port_a", 8'(exp.scl_port_a), 8'(got.scl_port_a));
               check_field("sda_port_a", 8'(exp.sda_port_a), 8'(got.sda_port_a));
               check_field("scl_port_b", 8'(exp.scl_port_b), 8'(got.scl_port_b));
               check_field("sda_port_b", 8'(exp.sda_port_b), 8'(got.sda_port_b));
               check_field("busy_res", 8'(exp.busy_res), 8'(got.busy_res));
               check_field("done_res", 8'(exp.done_res), 8'(got.done_res));
               check_field("status", 8'(exp.status), 8'(got.status));
               check_field("read_byte", exp.read_byte, got.read_byte);
            end
         end
      end
   end

   initial begin
      req_type    w;
      int         goal;
      logic [7:0] lim;
      logic [7:0] phase_limits [5];
      int         tx_pcts [5];
      int         rx_pcts [5];
      phase_limits = '{8'd1, 8'd255, 8'd0, 8'd0, CHECK_LIMIT_RESET};
      tx_pcts = '{0, 63, 0, 18, 0};
      rx_pcts = '{0, 0, 63, 18, 0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         w = '{dir_rows[i].kind, dir_rows[i].port, dir_rows[i].dev_addr,
               dir_rows[i].reg_offset, dir_rows[i].wr_byte, 1'b0};
         start_xfer(w, dir_rows[i].low_pulses, dir_rows[i].nack_at, dir_rows[i].rd_byte,
                    1'b0, 0);
         check_done(dir_rows[i].want_status, dir_rows[i].want_rbyte);
         w = noise_word();
         w.kind = KIND_SPARE;
         send_tick(w);
      end

      // lower the limit in the middle of a stuck bus check
      w = '{KIND_WRITE, 1'b1, 7'h6B, 8'h10, 8'h20, 1'b0};
      start_xfer(w, 8'd255, PH_IDLE, 8'h00, 1'b0, 24);
      write_limit(8'd1);
      run_ticks(0);
      check_done(STATUS_LOCKED, 8'h00);

      for (int p = 0; p < 5; p++) begin
         lim = (p == 3) ? 8'($urandom_range(2, 254)) : phase_limits[p];
         write_limit(lim);
         tx_idle_pct = tx_pcts[p];
         rx_stall_pct = rx_pcts[p];
         // hold the receiver off so the block backs up into its input
         if (p == 4) hold_request = 1'b1;
         goal = work_items + 270;
         while (work_items < goal) random_xfer();
      end

      drain();
      repeat (8) @(posedge clock);
      if (errors == 0 && line_state_q.size() == 0) begin
         $display("i2c_eeprom_byte_master: match");
      end else begin
         $display("i2c_eeprom_byte_master: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("i2c_eeprom_byte_master: mismatch");
      $finish;
   end

endmodule

@@ i2c_eeprom_byte_master.f @@
design/i2cebm_pkg.sv
design/i2cebm_engine.sv
design/i2c_eeprom_byte_master.sv
sim/i2c_eeprom_byte_master_tb.sv
